// ===== sv/ordered_array_list_engine_unit_defines.svh =====
// Assertion helpers used by the list engine RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OALE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/oale_pkg.sv =====
`timescale 1ns / 1ps

package oale_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [POS_W-1:0] NO_POS = 5'h1F;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_CONTAINS = 3'd4,
    OP_READ     = 3'd5,
    OP_FIND     = 3'd6,
    OP_NOP      = 3'd7
  } op_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_START = 2'd1,
    S_WALK  = 2'd2,
    S_DONE  = 2'd3
  } state_t;

endpackage

// ===== sv/oale_in_if.sv =====
`timescale 1ns / 1ps

interface oale_in_if import oale_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_mode_t             mode;
  logic [POS_W-1:0]     position;
  logic [FIELD_W-1:0]   entry_key;
  logic [FIELD_W-1:0]   entry_payload;

  modport source (output valid, mode, position, entry_key, entry_payload, input ready);
  modport sink   (input valid, mode, position, entry_key, entry_payload, output ready);
endinterface

// ===== sv/oale_out_if.sv =====
`timescale 1ns / 1ps

interface oale_out_if import oale_pkg::*; ();
  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic                      found;
  logic signed [POS_W-1:0]   found_position;
  logic [FIELD_W-1:0]        out_key;
  logic [FIELD_W-1:0]        out_payload;
  logic [POS_W-1:0]          entry_count;
  logic                      is_empty;
  logic                      is_full;

  modport source (output valid, status, found, found_position, out_key, out_payload,
                  entry_count, is_empty, is_full, input ready);
  modport sink   (input valid, status, found, found_position, out_key, out_payload,
                  entry_count, is_empty, is_full, output ready);
endinterface

// ===== sv/oale_ram.sv =====
`timescale 1ns / 1ps

module oale_ram import oale_pkg::*; #(
  parameter int WIDTH = KEY_BITS_DEF + PAYLOAD_BITS_DEF,
  parameter int DEPTH = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ordered_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY entries (key and payload) kept in one
// single-port-read entry RAM with a registered read. Each request
// selects append, insert, delete, replace, read, contains or find; every
// response carries a status (ok, full, bad position, empty), the entry
// count and the empty and full flags. One request is worked at a time:
// append, replace, rejected requests and the unused mode need no walk;
// insert, delete, read, contains and find walk the RAM read port over
// entries from the position to the end for insert and delete, one entry
// for read, and entries up to and including the first match for contains
// and find, all of them on a miss (none for an insert at the end or a
// search of an empty list). The RAM read port visits one entry per cycle.
// A stalled response holds the block in S_DONE until the response
// register frees. The response register lets the next request be taken
// while the last response still waits downstream.
`include "ordered_array_list_engine_unit_defines.svh"

module ordered_array_list_engine_unit import oale_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  oale_in_if.sink    in_chan,
  oale_out_if.source out_chan
);

  localparam int DW   = KEY_BITS + PAYLOAD_BITS;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;     // next RAM address to read
  logic [CW-1:0]     rd_left_r, rd_left_nxt;   // reads still to issue
  logic              pend_r, pend_nxt;         // read data arrives this cycle
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Latched request.
  op_mode_t          op_mode_r;
  logic [POS_W-1:0]  op_pos_r;
  logic [KEY_BITS-1:0]     op_key_r;
  logic [PAYLOAD_BITS-1:0] op_pay_r;

  // Result being built.
  status_t           res_status_r, res_status_nxt;
  logic              res_found_r, res_found_nxt;
  logic [POS_W-1:0]  res_fpos_r, res_fpos_nxt;
  logic [FIELD_W-1:0] res_key_r, res_key_nxt;
  logic [FIELD_W-1:0] res_pay_r, res_pay_nxt;

  // Response register.
  status_t           out_status_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_fpos_r;
  logic [FIELD_W-1:0] out_key_r;
  logic [FIELD_W-1:0] out_pay_r;
  logic [POS_W-1:0]  out_count_r;
  logic              out_empty_r;
  logic              out_full_r;

  // RAM port.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DW-1:0]     ram_rdata;

  logic              accept;
  logic              out_free;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cnt_x;
  logic              list_full;
  logic              list_empty;
  status_t           start_status;
  logic              start_walk;
  logic              walk_done;
  logic              key_hit;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  oale_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_chan.ready;

  assign pos_x      = CMPW'(op_pos_r);
  assign cnt_x      = CMPW'(count_r);
  assign list_full  = (count_r == CW'(CAPACITY));
  assign list_empty = (count_r == '0);

  assign rd_key     = ram_rdata[DW-1:PAYLOAD_BITS];
  assign rd_pay     = ram_rdata[PAYLOAD_BITS-1:0];
  assign key_hit    = pend_r && (rd_key == op_key_r);
  assign walk_done  = (rd_left_r == '0) && !pend_r;

  // Check the request against the list before touching the RAM.
  always_comb begin
    start_status = ST_OK;
    unique case (op_mode_r)
      OP_APPEND: begin
        if (list_full) start_status = ST_FULL;
      end
      OP_INSERT: begin
        if (list_full)          start_status = ST_FULL;
        else if (pos_x > cnt_x) start_status = ST_BADPOS;
      end
      OP_DELETE: begin
        if (list_empty)          start_status = ST_EMPTY;
        else if (pos_x >= cnt_x) start_status = ST_BADPOS;
      end
      OP_REPLACE, OP_READ: begin
        if (pos_x >= cnt_x) start_status = ST_BADPOS;
      end
      OP_CONTAINS, OP_FIND, OP_NOP: begin
        start_status = ST_OK;
      end
      default: start_status = ST_OK;
    endcase
  end

  always_comb begin
    case (op_mode_r) inside
      OP_INSERT, OP_DELETE, OP_READ, OP_CONTAINS, OP_FIND:
        start_walk = (start_status == ST_OK);
      default:
        start_walk = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_START;
      S_START: state_nxt = start_walk ? S_WALK : S_DONE;
      S_WALK:  if (walk_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_left_nxt    = rd_left_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_fpos_nxt   = res_fpos_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        out_valid_nxt = out_valid_r && !out_chan.ready;
      end

      S_START: begin
        res_status_nxt = start_status;
        res_found_nxt  = 1'b0;
        res_fpos_nxt   = NO_POS;
        res_key_nxt    = '0;
        res_pay_nxt    = '0;
        if (start_status == ST_OK) begin
          unique case (op_mode_r)
            OP_APPEND: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_r);
              ram_wdata = {op_key_r, op_pay_r};
              count_nxt = CW'(count_r + 1'b1);
            end
            OP_REPLACE: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(op_pos_r);
              ram_wdata = {op_key_r, op_pay_r};
            end
            OP_INSERT: begin
              // Walk down from the last entry to the position.
              rd_ptr_nxt  = AW'(count_r - 1'b1);
              rd_left_nxt = CW'(cnt_x - pos_x);
            end
            OP_DELETE: begin
              // Walk up from the position; its own entry is the removed one.
              rd_ptr_nxt  = AW'(op_pos_r);
              rd_left_nxt = CW'(cnt_x - pos_x);
            end
            OP_READ: begin
              rd_ptr_nxt  = AW'(op_pos_r);
              rd_left_nxt = CW'(1);
            end
            OP_CONTAINS, OP_FIND: begin
              rd_ptr_nxt  = '0;
              rd_left_nxt = count_r;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end

      S_WALK: begin
        // Issue the next read.
        if (rd_left_r != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = rd_ptr_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_ptr_r;
          rd_left_nxt   = CW'(rd_left_r - 1'b1);
          rd_ptr_nxt    = (op_mode_r == OP_INSERT) ? AW'(rd_ptr_r - 1'b1)
                                                   : AW'(rd_ptr_r + 1'b1);
        end
        // Consume the data read last cycle.
        if (pend_r) begin
          unique case (op_mode_r)
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pend_addr_r + 1'b1);
              ram_wdata = ram_rdata;
            end
            OP_DELETE: begin
              if (pend_addr_r == AW'(op_pos_r)) begin
                res_key_nxt = FIELD_W'(rd_key);
                res_pay_nxt = FIELD_W'(rd_pay);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pend_addr_r - 1'b1);
                ram_wdata = ram_rdata;
              end
            end
            OP_READ: begin
              res_key_nxt = FIELD_W'(rd_key);
              res_pay_nxt = FIELD_W'(rd_pay);
            end
            OP_CONTAINS, OP_FIND: begin
              if (key_hit) begin
                // First match: drop the read in flight and stop.
                res_found_nxt = 1'b1;
                res_fpos_nxt  = POS_W'(pend_addr_r);
                rd_left_nxt   = '0;
                pend_nxt      = 1'b0;
              end
            end
            default: begin
              pend_nxt = 1'b0;
            end
          endcase
        end
        // Close out the walk.
        if (walk_done) begin
          if (op_mode_r == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(op_pos_r);
            ram_wdata = {op_key_r, op_pay_r};
            count_nxt = CW'(count_r + 1'b1);
          end else if (op_mode_r == OP_DELETE) begin
            count_nxt = CW'(count_r - 1'b1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end

      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      rd_left_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_left_r   <= rd_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold the request, build and present the response.
  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_fpos_r   <= res_fpos_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    if (accept) begin
      op_mode_r <= in_chan.mode;
      op_pos_r  <= in_chan.position;
      op_key_r  <= in_chan.entry_key[KEY_BITS-1:0];
      op_pay_r  <= in_chan.entry_payload[PAYLOAD_BITS-1:0];
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_fpos_r   <= res_fpos_r;
      out_key_r    <= res_key_r;
      out_pay_r    <= res_pay_r;
      out_count_r  <= POS_W'(count_r);
      out_empty_r  <= list_empty;
      out_full_r   <= list_full;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.found          = out_found_r;
  assign out_chan.found_position = out_fpos_r;
  assign out_chan.out_key        = out_key_r;
  assign out_chan.out_payload    = out_pay_r;
  assign out_chan.entry_count    = out_count_r;
  assign out_chan.is_empty       = out_empty_r;
  assign out_chan.is_full        = out_full_r;

  // Never read and write the same RAM entry in one cycle: the walk order
  // must keep the read ahead of the shifted write.
  `OALE_ASSERT_IMPL(a_no_rw_overlap, ram_we && ram_re, ram_waddr != ram_raddr,
                    "entry RAM read and write collide")

  `OALE_ASSERT(a_count_bound, count_r <= CW'(CAPACITY),
               "entry count exceeds capacity")

  // Count moves only while a request is being worked.
  `OALE_ASSERT_IMPL(a_count_moves, !$stable(count_r),
                    $past(state_r) == S_START || $past(state_r) == S_WALK,
                    "entry count changed outside a request")

  // A response that reports a match carries an ok status.
  `OALE_ASSERT_IMPL(a_found_ok, out_valid_r && out_found_r, out_status_r == ST_OK,
                    "match reported with an error status")

endmodule
